// ----- sv/iips_pkg.sv -----
// package: types, codes and constants of the i2c imu poll sequencer
`timescale 1ns / 1ps
`default_nettype none
package iips_pkg;

    localparam int SETUP_SLOTS_DEF = 4;
    localparam int CMD_SLOTS       = 4;
    localparam int SAMPLE_BYTES    = 6;

    localparam int EVENT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CMD_W      = 24;
    localparam int COUNT_W    = 3;
    localparam int ADDR_W     = 7;
    localparam int SREG_W     = 16;

    // bus status events
    localparam logic [EVENT_W-1:0] EV_START     = 4'd0;
    localparam logic [EVENT_W-1:0] EV_RESTART   = 4'd1;
    localparam logic [EVENT_W-1:0] EV_WR_ADDR   = 4'd2;
    localparam logic [EVENT_W-1:0] EV_RD_ADDR   = 4'd3;
    localparam logic [EVENT_W-1:0] EV_WR_DATA   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_RD_ACK    = 4'd5;
    localparam logic [EVENT_W-1:0] EV_RD_NACK   = 4'd6;
    localparam logic [EVENT_W-1:0] EV_NONE      = 4'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CMD_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE   = 3'd7;

    // reset values
    localparam logic [CMD_W-1:0]   RST_CMD_A  = 24'h53_31_09;
    localparam logic [CMD_W-1:0]   RST_CMD_B  = 24'h53_2D_08;
    localparam logic [CMD_W-1:0]   RST_CMD_C  = 24'h68_15_09;
    localparam logic [CMD_W-1:0]   RST_CMD_D  = 24'h68_16_1A;
    localparam logic [COUNT_W-1:0] RST_COUNT  = 3'd4;
    localparam logic [ADDR_W-1:0]  RST_ACCEL  = 7'h53;
    localparam logic [ADDR_W-1:0]  RST_GYRO   = 7'h68;
    localparam logic [SREG_W-1:0]  RST_SAMPLE = 16'h32_1D;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [CMD_SLOTS-1:0][CMD_W-1:0] cmd;
        logic [COUNT_W-1:0]              init_count;
        logic [ADDR_W-1:0]               accel_address;
        logic [ADDR_W-1:0]               gyro_address;
        logic [SREG_W-1:0]               sample_registers;
    } t_cfg;

    typedef struct packed {
        logic               tx_load;
        t_byte              tx_byte;
        logic               want_start;
        logic               want_stop;
        logic               ack_next;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic               samples_valid;
    } t_result;

endpackage
`default_nettype wire

// ----- sv/iips_ifs.sv -----
// interfaces: bus event channel and result channel
`timescale 1ns / 1ps
`default_nettype none
interface iips_evt_if;
    import iips_pkg::*;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_req;
    logic [7:0]         rx_byte;
    modport source (output valid, event_req, rx_byte, input ready);
    modport sink   (input valid, event_req, rx_byte, output ready);
endinterface

interface iips_res_if;
    logic               valid;
    logic               ready;
    logic               tx_load;
    logic [7:0]         tx_byte;
    logic               want_start;
    logic               want_stop;
    logic               ack_next;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               samples_valid;
    modport source (output valid, tx_load, tx_byte, want_start, want_stop, ack_next,
                    accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, samples_valid,
                    input ready);
    modport sink   (input valid, tx_load, tx_byte, want_start, want_stop, ack_next,
                    accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, samples_valid,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/iips_cfg_regs.sv -----
// configuration register file with write decode
`timescale 1ns / 1ps
`default_nettype none
module iips_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [iips_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [iips_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output iips_pkg::t_cfg                       o_cfg
);
    import iips_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CMD_A:  n_cfg.cmd[0] = i_cfg_data[CMD_W-1:0];
                REG_CMD_B:  n_cfg.cmd[1] = i_cfg_data[CMD_W-1:0];
                REG_CMD_C:  n_cfg.cmd[2] = i_cfg_data[CMD_W-1:0];
                REG_CMD_D:  n_cfg.cmd[3] = i_cfg_data[CMD_W-1:0];
                REG_COUNT:  n_cfg.init_count = i_cfg_data[COUNT_W-1:0];
                REG_ACCEL:  n_cfg.accel_address = i_cfg_data[ADDR_W-1:0];
                REG_GYRO:   n_cfg.gyro_address = i_cfg_data[ADDR_W-1:0];
                REG_SAMPLE: n_cfg.sample_registers = i_cfg_data[SREG_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd[0]            <= RST_CMD_A;
            r_cfg.cmd[1]            <= RST_CMD_B;
            r_cfg.cmd[2]            <= RST_CMD_C;
            r_cfg.cmd[3]            <= RST_CMD_D;
            r_cfg.init_count        <= RST_COUNT;
            r_cfg.accel_address     <= RST_ACCEL;
            r_cfg.gyro_address      <= RST_GYRO;
            r_cfg.sample_registers  <= RST_SAMPLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- sv/i2c_imu_poll_sequencer.sv -----
// top level: i2c master sequencer that sets up and polls an accelerometer and a gyroscope
`timescale 1ns / 1ps
`default_nettype none
// One bus status event is taken per beat and answered by one result beat in
// the next cycle, from a result register; a new event is taken in every cycle
// while that register is empty or being read, so the sustained rate is one
// event per clock. The answer carries the byte to load into the shifter and
// the start, stop and acknowledge requests, plus the latest samples as they
// stand after that event. After reset the block sends up to init_count set-up writes
// (address, register pointer, value), then reads six bytes from the accelerometer and
// six from the gyro in turn; samples_valid rises after the first complete read. The user
// must write configuration only while idle; the block does not enforce it.
module i2c_imu_poll_sequencer #(
    parameter int SETUP_SLOTS = iips_pkg::SETUP_SLOTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [iips_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [iips_pkg::CFG_DATA_W-1:0] i_cfg_data,
    iips_evt_if.sink                             i_evt,
    iips_res_if.source                           o_res
);
    import iips_pkg::*;

    localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(SETUP_SLOTS);
    localparam logic [COUNT_W-1:0] LAST_BYTE  = COUNT_W'(SAMPLE_BYTES - 1);
    localparam logic [COUNT_W-1:0] FULL_READ  = COUNT_W'(SAMPLE_BYTES);

    t_cfg cfg;

    iips_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    logic [COUNT_W-1:0] r_setup_index, n_setup_index;
    logic               r_register_sent, n_register_sent;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic               r_reading_gyro, n_reading_gyro;
    t_byte              r_stage [SAMPLE_BYTES];
    t_byte              n_stage [SAMPLE_BYTES];
    t_byte              r_accel [SAMPLE_BYTES];
    t_byte              n_accel [SAMPLE_BYTES];
    t_byte              r_gyro  [SAMPLE_BYTES];
    t_byte              n_gyro  [SAMPLE_BYTES];
    logic               r_valid_flag, n_valid_flag;
    logic               r_res_valid, n_res_valid;
    t_result            r_res, n_res;

    logic               accept;
    logic               in_setup;
    logic [COUNT_W-1:0] limit;
    logic [CMD_W-1:0]   cur_cmd;
    logic [ADDR_W-1:0]  sensor_addr;
    logic [COUNT_W-1:0] count_inc;

    assign i_evt.ready = !r_res_valid || o_res.ready;
    assign accept      = i_evt.valid && i_evt.ready;

    assign limit       = (cfg.init_count > SLOT_LIMIT) ? SLOT_LIMIT : cfg.init_count;
    assign in_setup    = (r_setup_index < limit);
    assign cur_cmd     = cfg.cmd[r_setup_index[1:0]];
    assign sensor_addr = r_reading_gyro ? cfg.gyro_address : cfg.accel_address;
    assign count_inc   = r_byte_count + COUNT_W'(1);

    always_comb begin
        n_setup_index   = r_setup_index;
        n_register_sent = r_register_sent;
        n_byte_count    = r_byte_count;
        n_reading_gyro  = r_reading_gyro;
        n_valid_flag    = r_valid_flag;
        n_stage         = r_stage;
        n_accel         = r_accel;
        n_gyro          = r_gyro;
        n_res           = r_res;
        n_res_valid     = r_res_valid && !o_res.ready;

        if (accept) begin
            n_res.tx_load    = 1'b0;
            n_res.tx_byte    = 8'h00;
            n_res.want_start = 1'b0;
            n_res.want_stop  = 1'b0;
            n_res.ack_next   = 1'b0;
            case (i_evt.event_req)
                EV_START: begin
                    n_res.tx_load = 1'b1;
                    n_res.tx_byte = in_setup ? {cur_cmd[22:16], 1'b0} : {sensor_addr, 1'b0};
                end
                EV_RESTART: begin
                    n_res.tx_load  = 1'b1;
                    n_res.tx_byte  = {sensor_addr, 1'b1};
                    n_res.ack_next = 1'b1;
                end
                EV_WR_ADDR: begin
                    n_res.tx_load = 1'b1;
                    if (in_setup) begin
                        n_res.tx_byte   = cur_cmd[15:8];
                        n_register_sent = 1'b0;
                    end else if (r_reading_gyro) begin
                        n_res.tx_byte = cfg.sample_registers[7:0];
                    end else begin
                        n_res.tx_byte = cfg.sample_registers[15:8];
                    end
                end
                EV_RD_ADDR: begin
                    n_res.ack_next = 1'b1;
                end
                EV_WR_DATA: begin
                    if (in_setup) begin
                        if (!r_register_sent) begin
                            n_register_sent = 1'b1;
                            n_res.tx_load   = 1'b1;
                            n_res.tx_byte   = cur_cmd[7:0];
                        end else begin
                            n_res.want_start = 1'b1;
                            n_res.want_stop  = 1'b1;
                            n_setup_index    = r_setup_index + COUNT_W'(1);
                        end
                    end else begin
                        n_res.want_start = 1'b1;
                    end
                end
                EV_RD_ACK, EV_RD_NACK: begin
                    if (r_byte_count < FULL_READ) begin
                        n_stage[r_byte_count] = i_evt.rx_byte;
                    end
                    n_byte_count = count_inc;
                    if (count_inc >= FULL_READ) begin
                        n_byte_count = '0;
                        if (r_reading_gyro) begin
                            n_gyro = n_stage;
                        end else begin
                            n_accel = n_stage;
                        end
                        n_reading_gyro   = !r_reading_gyro;
                        n_valid_flag     = 1'b1;
                        n_res.want_start = 1'b1;
                        n_res.want_stop  = 1'b1;
                    end else begin
                        n_res.ack_next = (count_inc != LAST_BYTE);
                    end
                end
                EV_NONE: begin
                end
                default: begin
                    n_res.want_start = 1'b1;
                    n_res.want_stop  = 1'b1;
                end
            endcase
            // accelerometer little-endian, gyro big-endian
            n_res.accel_x       = {n_accel[1], n_accel[0]};
            n_res.accel_y       = {n_accel[3], n_accel[2]};
            n_res.accel_z       = {n_accel[5], n_accel[4]};
            n_res.gyro_x        = {n_gyro[0], n_gyro[1]};
            n_res.gyro_y        = {n_gyro[2], n_gyro[3]};
            n_res.gyro_z        = {n_gyro[4], n_gyro[5]};
            n_res.samples_valid = n_valid_flag;
            n_res_valid         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_index   <= '0;
            r_register_sent <= 1'b0;
            r_byte_count    <= '0;
            r_reading_gyro  <= 1'b0;
            r_valid_flag    <= 1'b0;
            r_res_valid     <= 1'b0;
            for (int i = 0; i < SAMPLE_BYTES; i++) begin
                r_accel[i] <= '0;
                r_gyro[i]  <= '0;
            end
        end else begin
            r_setup_index   <= n_setup_index;
            r_register_sent <= n_register_sent;
            r_byte_count    <= n_byte_count;
            r_reading_gyro  <= n_reading_gyro;
            r_valid_flag    <= n_valid_flag;
            r_res_valid     <= n_res_valid;
            r_accel         <= n_accel;
            r_gyro          <= n_gyro;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        r_res   <= n_res;
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.tx_load       = r_res.tx_load;
    assign o_res.tx_byte       = r_res.tx_byte;
    assign o_res.want_start    = r_res.want_start;
    assign o_res.want_stop     = r_res.want_stop;
    assign o_res.ack_next      = r_res.ack_next;
    assign o_res.accel_x       = r_res.accel_x;
    assign o_res.accel_y       = r_res.accel_y;
    assign o_res.accel_z       = r_res.accel_z;
    assign o_res.gyro_x        = r_res.gyro_x;
    assign o_res.gyro_y        = r_res.gyro_y;
    assign o_res.gyro_z        = r_res.gyro_z;
    assign o_res.samples_valid = r_res.samples_valid;

    a_byte_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count < FULL_READ)
        else $error("byte count past end of read");

    a_setup_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_setup_index <= SLOT_LIMIT)
        else $error("set-up index past slot count");

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_flag |=> r_valid_flag)
        else $error("samples valid flag fell");

    a_tx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.tx_load) |-> (r_res.tx_byte == 8'h00))
        else $error("tx byte not zero without load");

    a_side_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reading_gyro != $past(r_reading_gyro)) |-> (r_byte_count == '0))
        else $error("sensor switched mid read");

endmodule
`default_nettype wire
